// ----- design/tsp_pkg.sv -----
// Shared types and constants for the timed slot pool.
`default_nettype none

package tsp_pkg;

    // Fixed field widths.
    localparam int TIME_W = 32;
    localparam int LIFE_W = 24;
    localparam int SLOT_W = 5;

    // Register port geometry.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register indexes, decoded from the word address bit.
    localparam logic REG_MARK_LIFE  = 1'b0;
    localparam logic REG_TRACE_LIFE = 1'b1;

    // Register reset values.
    localparam logic [LIFE_W-1:0] MARK_LIFE_RST  = 24'd50000;
    localparam logic [LIFE_W-1:0] TRACE_LIFE_RST = 24'd100;

    // Operation codes of an input beat.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Lifetime registers as seen by the sequencer.
    typedef struct packed {
        logic [LIFE_W-1:0] mark_life;
        logic [LIFE_W-1:0] trace_life;
    } t_cfg;

    // Request to the shared adder: cmp selects a compare (a < b) over a sum.
    typedef struct packed {
        logic              cmp;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              lt;
    } t_alu_rsp;

    // One result beat.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [SLOT_W-1:0] evicted_slot;
        logic              valid_res;
        logic              last;
    } t_result;

    function automatic t_result mk_res(logic [SLOT_W-1:0] slot, logic ev,
                                       logic [SLOT_W-1:0] evs, logic vld,
                                       logic lst);
        t_result r;
        r.slot         = slot;
        r.evicted      = ev;
        r.evicted_slot = evs;
        r.valid_res    = vld;
        r.last         = lst;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/timed_slot_pool_oldest_evict.sv -----
// Top level of the timed slot pool: registers, sequencer, adder and output stage.
//
// Input channel: i_in_valid / o_in_stall with i_operation, i_is_trace and i_now.
// An insert takes a free slot (evicting the oldest live entry when none is free)
// and gives one result beat. A tick walks the live entries from newest to oldest
// and gives one beat per expired entry, or one beat with o_valid_res low when
// nothing expired; o_last marks the final beat of each input beat.
// Output channel: o_out_valid / i_out_stall; the result sits in an output
// register, so the sequencer moves on while the receiver stalls, until the next
// result is ready and the register is still full.
// An insert passes S_INS0 to S_INS3 on its way to the output register, with a
// release between S_INS0 and S_INS1 when it evicts; a tick releases each expired
// entry as its walk meets it. A release reads the links of the slot, then joins
// its neighbours around it and pushes the slot onto the free list.
// One input beat is worked on at a time; o_in_stall is high until its last
// result has been handed to the output register.
// Reset (synchronous, active low) empties the pool and sets the lifetimes to
// 50000 and 100. The lifetime registers are written through the APB-style port.
`default_nettype none

module timed_slot_pool_oldest_evict #(
    parameter int POOL_SIZE = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_operation,
    input  wire logic                          i_is_trace,
    input  wire logic [tsp_pkg::TIME_W-1:0]    i_now,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [tsp_pkg::SLOT_W-1:0]         o_slot,
    output logic                               o_evicted,
    output logic [tsp_pkg::SLOT_W-1:0]         o_evicted_slot,
    output logic                               o_valid_res,
    output logic                               o_last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tsp_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [tsp_pkg::DATA_W-1:0]    pwdata,
    output logic      [tsp_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    tsp_pkg::t_cfg     w_cfg;
    tsp_pkg::t_alu_req w_alu_req;
    tsp_pkg::t_alu_rsp w_alu_rsp;
    tsp_pkg::t_result  w_res;
    logic              w_res_valid;
    logic              w_res_ready;

    logic              r_out_valid;
    tsp_pkg::t_result  r_out;

    tsp_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    tsp_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    tsp_seq #(
        .POOL_SIZE (POOL_SIZE)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_is_trace  (i_is_trace),
        .i_now       (i_now),
        .i_cfg       (w_cfg),
        .o_alu_req   (w_alu_req),
        .i_alu_rsp   (w_alu_rsp),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // The output register takes a new beat when empty or being drained.
    assign w_res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_slot         = r_out.slot;
    assign o_evicted      = r_out.evicted;
    assign o_evicted_slot = r_out.evicted_slot;
    assign o_valid_res    = r_out.valid_res;
    assign o_last         = r_out.last;

endmodule

`default_nettype wire

// ----- design/tsp_regs.sv -----
// Configuration register file for the two lifetimes, APB-style access.
`default_nettype none

module tsp_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_psel,
    input  wire logic                         i_penable,
    input  wire logic                         i_pwrite,
    input  wire logic [tsp_pkg::ADDR_W-1:0]   i_paddr,
    input  wire logic [tsp_pkg::DATA_W-1:0]   i_pwdata,
    output logic      [tsp_pkg::DATA_W-1:0]   o_prdata,
    output logic                              o_pready,
    output tsp_pkg::t_cfg                     o_cfg
);

    logic [tsp_pkg::LIFE_W-1:0] r_mark_life;
    logic [tsp_pkg::LIFE_W-1:0] r_trace_life;
    logic                       w_wr;

    // The access phase of a write completes at once.
    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite;

    // Register writes; the word address bit picks the register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_life  <= tsp_pkg::MARK_LIFE_RST;
            r_trace_life <= tsp_pkg::TRACE_LIFE_RST;
        end else if (w_wr) begin
            case (i_paddr[2])
                tsp_pkg::REG_MARK_LIFE:  r_mark_life  <= i_pwdata[tsp_pkg::LIFE_W-1:0];
                tsp_pkg::REG_TRACE_LIFE: r_trace_life <= i_pwdata[tsp_pkg::LIFE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back of the addressed register.
    always_comb begin
        case (i_paddr[2])
            tsp_pkg::REG_MARK_LIFE:
                o_prdata = tsp_pkg::DATA_W'(r_mark_life);
            tsp_pkg::REG_TRACE_LIFE:
                o_prdata = tsp_pkg::DATA_W'(r_trace_life);
            default:
                o_prdata = '0;
        endcase
    end

    assign o_cfg.mark_life  = r_mark_life;
    assign o_cfg.trace_life = r_trace_life;

endmodule

`default_nettype wire

// ----- design/tsp_alu.sv -----
// Shared 32-bit adder that forms expiry times and compares them with now.
`default_nettype none

module tsp_alu (
    input  wire tsp_pkg::t_alu_req i_req,
    output tsp_pkg::t_alu_rsp      o_rsp
);

    logic [tsp_pkg::TIME_W-1:0] w_b;
    logic [tsp_pkg::TIME_W:0]   w_full;

    // A compare is a subtraction; a missing carry means a < b.
    assign w_b    = i_req.cmp ? ~i_req.b : i_req.b;
    assign w_full = {1'b0, i_req.a} + {1'b0, w_b}
                  + {{tsp_pkg::TIME_W{1'b0}}, i_req.cmp};

    assign o_rsp.sum = w_full[tsp_pkg::TIME_W-1:0];
    assign o_rsp.lt  = i_req.cmp & ~w_full[tsp_pkg::TIME_W];

endmodule

`default_nettype wire

// ----- design/tsp_seq.sv -----
// Sequencer with the link and expiry memories: insert, evict and expiry walk.
`default_nettype none

module tsp_seq #(
    parameter int POOL_SIZE = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_operation,
    input  wire logic                        i_is_trace,
    input  wire logic [tsp_pkg::TIME_W-1:0]  i_now,
    input  wire tsp_pkg::t_cfg               i_cfg,
    output tsp_pkg::t_alu_req                o_alu_req,
    input  wire tsp_pkg::t_alu_rsp           i_alu_rsp,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output tsp_pkg::t_result                 o_res
);

    localparam int LW    = $clog2(POOL_SIZE + 1);
    localparam int SW    = $clog2(POOL_SIZE);
    localparam int STW   = $clog2(POOL_SIZE + 2);
    localparam int SlotW = tsp_pkg::SLOT_W;
    localparam int TW    = tsp_pkg::TIME_W;
    localparam logic [LW-1:0]  SENT    = LW'(POOL_SIZE);
    localparam logic [STW-1:0] MAX_STP = STW'(POOL_SIZE);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INS0 = 4'd1;
    localparam logic [3:0] S_INS1 = 4'd2;
    localparam logic [3:0] S_INS2 = 4'd3;
    localparam logic [3:0] S_INS3 = 4'd4;
    localparam logic [3:0] S_REL0 = 4'd5;
    localparam logic [3:0] S_REL1 = 4'd6;
    localparam logic [3:0] S_REL2 = 4'd7;
    localparam logic [3:0] S_TCK0 = 4'd8;
    localparam logic [3:0] S_WALK = 4'd9;
    localparam logic [3:0] S_PEND = 4'd10;
    localparam logic [3:0] S_ADV  = 4'd11;
    localparam logic [3:0] S_TEND = 4'd12;
    localparam logic [3:0] S_EMIT = 4'd13;

    // Link and expiry memories, one entry per slot.
    logic [LW-1:0] mem_next [POOL_SIZE];
    logic [LW-1:0] mem_prev [POOL_SIZE];
    logic [TW-1:0] mem_exp  [POOL_SIZE];

    logic [LW-1:0] r_next_q, r_prev_q;
    logic [TW-1:0] r_exp_q;

    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          nx_we, pv_we, ex_we;
    logic [SW-1:0] nx_waddr, pv_waddr, ex_waddr;
    logic [LW-1:0] nx_wdata, pv_wdata;

    // Control and working registers.
    logic [3:0]       r_state, n_state, r_ret, n_ret;
    logic             r_op, n_op, r_trace, n_trace;
    logic [TW-1:0]    r_now, n_now;
    logic [LW-1:0]    r_head, n_head, r_tail, n_tail;
    logic [LW-1:0]    r_free_head, n_free_head;
    logic             r_free_empty, n_free_empty;
    logic [LW-1:0]    r_fill, n_fill;
    logic [LW-1:0]    r_cur, n_cur, r_nxt, n_nxt;
    logic [STW-1:0]   r_steps, n_steps;
    logic             r_pend_valid, n_pend_valid;
    logic [LW-1:0]    r_pend_slot, n_pend_slot;
    logic             r_evicted, n_evicted;
    logic [LW-1:0]    r_evs, n_evs;
    logic [LW-1:0]    r_slot, n_slot, r_rel, n_rel;
    tsp_pkg::t_result r_res, n_res;

    logic             w_fresh;
    logic [LW-1:0]    w_ins_nx;
    logic [STW-1:0]   w_steps_inc;
    logic [tsp_pkg::LIFE_W-1:0] w_life;

    // A slot never taken before still links to its successor in slot order.
    assign w_fresh     = (r_slot >= r_fill);
    assign w_ins_nx    = w_fresh ? (r_slot + LW'(1)) : r_next_q;
    assign w_steps_inc = r_steps + STW'(1);
    assign w_life      = r_trace ? i_cfg.trace_life : i_cfg.mark_life;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;

    // Memory ports: one write and one registered read per memory and cycle.
    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            mem_next[nx_waddr] <= nx_wdata;
        end
        if (pv_we) begin
            mem_prev[pv_waddr] <= pv_wdata;
        end
        if (ex_we) begin
            mem_exp[ex_waddr] <= i_alu_rsp.sum;
        end
        if (rd_en) begin
            r_next_q <= mem_next[rd_addr];
            r_prev_q <= mem_prev[rd_addr];
            r_exp_q  <= mem_exp[rd_addr];
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_op         = r_op;
        n_trace      = r_trace;
        n_now        = r_now;
        n_head       = r_head;
        n_tail       = r_tail;
        n_free_head  = r_free_head;
        n_free_empty = r_free_empty;
        n_fill       = r_fill;
        n_cur        = r_cur;
        n_nxt        = r_nxt;
        n_steps      = r_steps;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_evicted    = r_evicted;
        n_evs        = r_evs;
        n_slot       = r_slot;
        n_rel        = r_rel;
        n_res        = r_res;
        rd_en        = 1'b0;
        rd_addr      = r_cur[SW-1:0];
        nx_we        = 1'b0;
        nx_waddr     = r_slot[SW-1:0];
        nx_wdata     = r_head;
        pv_we        = 1'b0;
        pv_waddr     = r_slot[SW-1:0];
        pv_wdata     = SENT;
        ex_we        = 1'b0;
        ex_waddr     = r_slot[SW-1:0];
        o_alu_req.cmp = 1'b1;
        o_alu_req.a   = r_exp_q;
        o_alu_req.b   = r_now;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_operation;
                    n_trace = i_is_trace;
                    n_now   = i_now;
                    n_state = (i_operation == tsp_pkg::OP_TICK) ? S_TCK0 : S_INS0;
                end
            end

            // Make room by evicting the oldest entry when nothing is free.
            S_INS0: begin
                n_evicted = 1'b0;
                n_evs     = '0;
                if (!r_free_empty) begin
                    n_state = S_INS1;
                end else if (r_tail != SENT) begin
                    n_evicted = 1'b1;
                    n_evs     = r_tail;
                    n_rel     = r_tail;
                    n_state   = S_REL0;
                end else begin
                    n_res   = tsp_pkg::mk_res('0, 1'b0, '0, 1'b0, 1'b1);
                    n_ret   = S_IDLE;
                    n_state = S_EMIT;
                end
            end

            // Release: read both links of the slot.
            S_REL0: begin
                rd_en   = 1'b1;
                rd_addr = r_rel[SW-1:0];
                n_state = S_REL1;
            end

            // Release: join the neighbours around the slot.
            S_REL1: begin
                if (r_prev_q == SENT) begin
                    n_head = r_next_q;
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = r_prev_q[SW-1:0];
                    nx_wdata = r_next_q;
                end
                if (r_next_q == SENT) begin
                    n_tail = r_prev_q;
                end else begin
                    pv_we    = 1'b1;
                    pv_waddr = r_next_q[SW-1:0];
                    pv_wdata = r_prev_q;
                end
                n_state = S_REL2;
            end

            // Release: push the slot onto the free list.
            S_REL2: begin
                nx_we        = 1'b1;
                nx_waddr     = r_rel[SW-1:0];
                nx_wdata     = r_free_empty ? SENT : r_free_head;
                n_free_head  = r_rel;
                n_free_empty = 1'b0;
                n_state      = (r_op == tsp_pkg::OP_TICK) ? S_PEND : S_INS1;
            end

            // Take the free head and fetch its link.
            S_INS1: begin
                if (r_free_empty || (r_free_head == SENT)) begin
                    n_res   = tsp_pkg::mk_res('0, r_evicted, SlotW'(r_evs), 1'b0, 1'b1);
                    n_ret   = S_IDLE;
                    n_state = S_EMIT;
                end else begin
                    n_slot  = r_free_head;
                    rd_en   = 1'b1;
                    rd_addr = r_free_head[SW-1:0];
                    n_state = S_INS2;
                end
            end

            // Advance the free list; link the slot in front and write its expiry.
            S_INS2: begin
                if (w_fresh) begin
                    n_fill = r_slot + LW'(1);
                end
                if (w_ins_nx == SENT) begin
                    n_free_empty = 1'b1;
                end else begin
                    n_free_head = w_ins_nx;
                end
                nx_we         = 1'b1;
                nx_wdata      = r_head;
                pv_we         = 1'b1;
                pv_wdata      = SENT;
                ex_we         = 1'b1;
                o_alu_req.cmp = 1'b0;
                o_alu_req.a   = r_now;
                o_alu_req.b   = TW'(w_life);
                n_state       = S_INS3;
            end

            // Point the old head back at the new slot and report it.
            S_INS3: begin
                if (r_head == SENT) begin
                    n_tail = r_slot;
                end else begin
                    pv_we    = 1'b1;
                    pv_waddr = r_head[SW-1:0];
                    pv_wdata = r_slot;
                end
                n_head  = r_slot;
                n_res   = tsp_pkg::mk_res(SlotW'(r_slot), r_evicted, SlotW'(r_evs),
                                          1'b1, 1'b1);
                n_ret   = S_IDLE;
                n_state = S_EMIT;
            end

            // Start the walk at the newest entry.
            S_TCK0: begin
                n_pend_valid = 1'b0;
                n_steps      = '0;
                if (r_head == SENT) begin
                    n_state = S_TEND;
                end else begin
                    n_cur   = r_head;
                    rd_en   = 1'b1;
                    rd_addr = r_head[SW-1:0];
                    n_state = S_WALK;
                end
            end

            // One entry a cycle; an expired one branches off to be released.
            S_WALK: begin
                n_steps = w_steps_inc;
                n_nxt   = r_next_q;
                if (i_alu_rsp.lt) begin
                    n_rel   = r_cur;
                    n_state = S_REL0;
                end else if ((r_next_q != SENT) && (w_steps_inc <= MAX_STP)) begin
                    n_cur   = r_next_q;
                    rd_en   = 1'b1;
                    rd_addr = r_next_q[SW-1:0];
                end else begin
                    n_state = S_TEND;
                end
            end

            // Hold back the latest expiry found so that the final one can carry last.
            S_PEND: begin
                n_pend_valid = 1'b1;
                n_pend_slot  = r_rel;
                if (r_pend_valid) begin
                    n_res   = tsp_pkg::mk_res(SlotW'(r_pend_slot), 1'b0, '0,
                                              1'b1, 1'b0);
                    n_ret   = S_ADV;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_ADV;
                end
            end

            S_ADV: begin
                if ((r_nxt != SENT) && (r_steps <= MAX_STP)) begin
                    n_cur   = r_nxt;
                    rd_en   = 1'b1;
                    rd_addr = r_nxt[SW-1:0];
                    n_state = S_WALK;
                end else begin
                    n_state = S_TEND;
                end
            end

            // Final beat of a tick.
            S_TEND: begin
                if (r_pend_valid) begin
                    n_res = tsp_pkg::mk_res(SlotW'(r_pend_slot), 1'b0, '0, 1'b1, 1'b1);
                end else begin
                    n_res = tsp_pkg::mk_res('0, 1'b0, '0, 1'b0, 1'b1);
                end
                n_ret   = S_IDLE;
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = r_ret;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= SENT;
            r_tail       <= SENT;
            r_free_head  <= '0;
            r_free_empty <= 1'b0;
            r_fill       <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_free_head  <= n_free_head;
            r_free_empty <= n_free_empty;
            r_fill       <= n_fill;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_ret       <= n_ret;
        r_op        <= n_op;
        r_trace     <= n_trace;
        r_now       <= n_now;
        r_cur       <= n_cur;
        r_nxt       <= n_nxt;
        r_steps     <= n_steps;
        r_pend_slot <= n_pend_slot;
        r_evicted   <= n_evicted;
        r_evs       <= n_evs;
        r_slot      <= n_slot;
        r_rel       <= n_rel;
        r_res       <= n_res;
    end

endmodule

`default_nettype wire

// ----- design/tsp_checker.sv -----
// Port-level checker for the timed slot pool, bound to the top level.
`default_nettype none

module tsp_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic [tsp_pkg::SLOT_W-1:0] o_slot,
    input wire logic                       o_evicted,
    input wire logic [tsp_pkg::SLOT_W-1:0] o_evicted_slot,
    input wire logic                       o_valid_res,
    input wire logic                       o_last
);

    // An accepted beat keeps the input side stalled on the next cycle.
    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted beat");

    // No new beat is taken while a result that is not the last one is waiting.
    a_no_accept_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !(o_out_valid && !o_last))
        else $error("input accepted while an item is still producing results");

    // A result without a live slot is always the only and final one.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |-> o_last)
        else $error("result without a slot is not marked last");

    // The evicted slot reads zero unless an eviction is reported.
    a_evs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_evicted) |-> (o_evicted_slot == '0))
        else $error("evicted slot set without an eviction");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_slot)
            && $stable(o_last) && $stable(o_valid_res)))
        else $error("stalled result beat changed");

endmodule

bind timed_slot_pool_oldest_evict tsp_checker u_tsp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_slot         (o_slot),
    .o_evicted      (o_evicted),
    .o_evicted_slot (o_evicted_slot),
    .o_valid_res    (o_valid_res),
    .o_last         (o_last)
);

`default_nettype wire

// ----- sim/tb_timed_slot_pool_oldest_evict.sv -----
// Self-checking testbench for the timed slot pool with oldest-entry eviction.
`timescale 1ns / 1ps

module tb_timed_slot_pool_oldest_evict;

    localparam int POOL        = 32;
    localparam int SENT        = POOL;
    localparam int CYCLE_LIMIT = 1000000;

    // One input beat as queued for the driver.
    typedef struct packed {
        logic                       op;
        logic                       trace;
        logic [tsp_pkg::TIME_W-1:0] now;
    } t_pool_cmd;

    // Clock, reset and all block inputs start at known values.
    logic                       i_clk     = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_op     = tsp_pkg::OP_INSERT;
    logic                       in_trace  = 1'b0;
    logic [tsp_pkg::TIME_W-1:0] in_now    = '0;
    logic                       out_stall = 1'b0;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [tsp_pkg::ADDR_W-1:0] paddr     = '0;
    logic [tsp_pkg::DATA_W-1:0] pwdata    = '0;

    wire logic                       in_stall;
    wire logic                       out_valid;
    wire logic [tsp_pkg::SLOT_W-1:0] out_slot;
    wire logic                       out_evicted;
    wire logic [tsp_pkg::SLOT_W-1:0] out_evicted_slot;
    wire logic                       out_valid_res;
    wire logic                       out_last;
    wire logic [tsp_pkg::DATA_W-1:0] prdata;
    wire logic                       pready;

    timed_slot_pool_oldest_evict #(
        .POOL_SIZE(POOL)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (in_op),
        .i_is_trace     (in_trace),
        .i_now          (in_now),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_slot         (out_slot),
        .o_evicted      (out_evicted),
        .o_evicted_slot (out_evicted_slot),
        .o_valid_res    (out_valid_res),
        .o_last         (out_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Predicted pool state: links, deadlines, free list and lifetimes.
    logic [5:0]                 fwd_link  [0:SENT];
    logic [5:0]                 back_link [0:SENT];
    logic [tsp_pkg::TIME_W-1:0] deadline  [0:POOL-1];
    logic [5:0]                 free_top;
    logic                       no_free;
    logic [tsp_pkg::LIFE_W-1:0] life_ordinary;
    logic [tsp_pkg::LIFE_W-1:0] life_trace;

    t_pool_cmd        cmd_queue[$];
    tsp_pkg::t_result expected_beats[$];
    t_pool_cmd        next_cmd;
    tsp_pkg::t_result want_beat;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches    = 0;
    int          beats_seen    = 0;
    int          cycle_count   = 0;
    int          n_inserts     = 0;
    int          n_evicted     = 0;
    int          n_ticks       = 0;
    int          n_expired     = 0;
    int          n_settings    = 0;
    logic [31:0] sim_now;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Take a live slot off the in-use list and push it onto the free list.
    function automatic void retire_slot(int s);
        int p;
        int n;
        p = int'(back_link[s]);
        n = int'(fwd_link[s]);
        fwd_link[p]  = 6'(n);
        back_link[n] = 6'(p);
        fwd_link[s]  = no_free ? 6'(SENT) : free_top;
        free_top     = 6'(s);
        no_free      = 1'b0;
    endfunction

    // An insert gives exactly one beat, evicting the oldest entry when full.
    function automatic void predict_insert(logic trace, logic [tsp_pkg::TIME_W-1:0] now);
        tsp_pkg::t_result beat;
        int               s;
        int               n;
        int               nx;
        beat = '0;
        beat.last = 1'b1;
        if (no_free) begin
            s = int'(back_link[SENT]);
            if (s != SENT) begin
                beat.evicted      = 1'b1;
                beat.evicted_slot = 5'(s);
                retire_slot(s);
                n_evicted++;
            end
        end
        s = int'(free_top);
        if (no_free || s == SENT) begin
            expected_beats.push_back(beat);
            return;
        end
        nx = int'(fwd_link[s]);
        if (nx == SENT) begin
            no_free = 1'b1;
        end else begin
            free_top = 6'(nx);
        end
        n = int'(fwd_link[SENT]);
        back_link[s]   = 6'(SENT);
        fwd_link[s]    = 6'(n);
        back_link[n]   = 6'(s);
        fwd_link[SENT] = 6'(s);
        deadline[s] = now + (trace ? {8'h00, life_trace} : {8'h00, life_ordinary});
        beat.slot      = 5'(s);
        beat.valid_res = 1'b1;
        expected_beats.push_back(beat);
        n_inserts++;
    endfunction

    // A tick frees every entry whose deadline lies strictly below now, newest first.
    function automatic void predict_tick(logic [tsp_pkg::TIME_W-1:0] now);
        tsp_pkg::t_result beat;
        int               cur;
        int               nxt;
        int               steps;
        int               freed[$];
        cur   = int'(fwd_link[SENT]);
        steps = 0;
        while (cur != SENT && steps <= POOL) begin
            nxt = int'(fwd_link[cur]);
            if (deadline[cur] < now) begin
                retire_slot(cur);
                freed.push_back(cur);
            end
            cur = nxt;
            steps++;
        end
        n_ticks++;
        n_expired += freed.size();
        if (freed.size() == 0) begin
            beat = '0;
            beat.last = 1'b1;
            expected_beats.push_back(beat);
        end else begin
            foreach (freed[i]) begin
                beat = '0;
                beat.slot      = 5'(freed[i]);
                beat.valid_res = 1'b1;
                beat.last      = (i == freed.size() - 1);
                expected_beats.push_back(beat);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("beat %0d: %s: got %0d, expected %0d", beats_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Driver: presents queued beats, predicting each one at its acceptance.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                if (in_op == tsp_pkg::OP_INSERT) begin
                    predict_insert(in_trace, in_now);
                end else begin
                    predict_tick(in_now);
                end
            end
            if (!in_valid || !in_stall) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_cmd = cmd_queue.pop_front();
                    in_op    <= next_cmd.op;
                    in_trace <= next_cmd.trace;
                    in_now   <= next_cmd.now;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("result beat with nothing expected", 32'(out_slot), 0);
                end else begin
                    want_beat = expected_beats.pop_front();
                    check_field("slot", 32'(out_slot), 32'(want_beat.slot));
                    check_field("evicted", 32'(out_evicted), 32'(want_beat.evicted));
                    check_field("evicted_slot", 32'(out_evicted_slot),
                                32'(want_beat.evicted_slot));
                    check_field("valid_res", 32'(out_valid_res), 32'(want_beat.valid_res));
                    check_field("last", 32'(out_last), 32'(want_beat.last));
                end
                beats_seen++;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_cmd(input logic op, input logic trace,
                           input logic [tsp_pkg::TIME_W-1:0] now);
        t_pool_cmd c;
        c.op    = op;
        c.trace = trace;
        c.now   = now;
        cmd_queue.push_back(c);
    endtask

    // Register write with a setup and an access phase; the predictor picks up the masked value.
    task automatic write_lifetime(input logic idx, input logic [tsp_pkg::DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tsp_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == tsp_pkg::REG_MARK_LIFE) begin
            life_ordinary = value[tsp_pkg::LIFE_W-1:0];
        end else begin
            life_trace = value[tsp_pkg::LIFE_W-1:0];
        end
        n_settings++;
    endtask

    // Hold the sender back until every queued beat is in and every result is out.
    task automatic wait_idle();
        while (!(cmd_queue.size() == 0 && !in_valid && expected_beats.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Random stimulus: mostly timelines of inserts and ticks with a moving clock,
    // some insert runs longer than the pool, and a little fully random noise.
    task automatic queue_random(input int count);
        int made;
        int len;
        int kind;
        made    = 0;
        sim_now = $urandom();
        while (made < count) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                len = $urandom_range(33, 40);
                repeat (len) begin
                    add_cmd(tsp_pkg::OP_INSERT, 1'($urandom_range(1)), sim_now);
                    sim_now += $urandom_range(0, 20);
                end
            end else if (kind < 88) begin
                len = $urandom_range(8, 30);
                repeat (len) begin
                    if ($urandom_range(99) < 60) begin
                        add_cmd(tsp_pkg::OP_INSERT, 1'($urandom_range(1)), sim_now);
                    end else begin
                        add_cmd(tsp_pkg::OP_TICK, 1'($urandom_range(1)), sim_now);
                    end
                    if ($urandom_range(9) == 0) begin
                        sim_now += $urandom_range(0, 70000);
                    end else begin
                        sim_now += $urandom_range(0, 150);
                    end
                end
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) begin
                    add_cmd(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
                end
            end
            made += len;
        end
    endtask

    initial begin
        // Predictor starts from the reset state: free chain in slot order.
        for (int i = 0; i < POOL; i++) begin
            fwd_link[i]  = 6'(i + 1);
            back_link[i] = '0;
            deadline[i]  = '0;
        end
        fwd_link[SENT]  = 6'(SENT);
        back_link[SENT] = 6'(SENT);
        free_top        = '0;
        no_free         = 1'b0;
        life_ordinary   = tsp_pkg::MARK_LIFE_RST;
        life_trace      = tsp_pkg::TRACE_LIFE_RST;

        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with reset lifetimes: empty ticks, equal deadline,
        // deadlines wrapping past the top of the time range, extremes of now.
        add_cmd(tsp_pkg::OP_TICK,   1'b0, 32'h0000_0000);
        add_cmd(tsp_pkg::OP_INSERT, 1'b1, 32'h0000_0000);
        add_cmd(tsp_pkg::OP_INSERT, 1'b0, 32'h0000_0000);
        add_cmd(tsp_pkg::OP_TICK,   1'b0, 32'd100);
        add_cmd(tsp_pkg::OP_TICK,   1'b1, 32'd101);
        add_cmd(tsp_pkg::OP_INSERT, 1'b1, 32'hFFFF_FFFF);
        add_cmd(tsp_pkg::OP_INSERT, 1'b0, 32'hFFFF_0000);
        add_cmd(tsp_pkg::OP_TICK,   1'b0, 32'd100);
        add_cmd(tsp_pkg::OP_TICK,   1'b0, 32'd50001);
        add_cmd(tsp_pkg::OP_TICK,   1'b0, 32'hFFFF_FFFF);
        add_cmd(tsp_pkg::OP_TICK,   1'b1, 32'hFFFF_FFFF);
        add_cmd(tsp_pkg::OP_INSERT, 1'b0, 32'h5555_5555);
        add_cmd(tsp_pkg::OP_INSERT, 1'b1, 32'hAAAA_AAAA);
        add_cmd(tsp_pkg::OP_TICK,   1'b0, 32'h8000_0000);
        add_cmd(tsp_pkg::OP_TICK,   1'b0, 32'h0000_0000);
        wait_idle();

        // Zero ordinary life and full trace life, the upper data bits set.
        write_lifetime(tsp_pkg::REG_MARK_LIFE, 32'h0000_0000);
        write_lifetime(tsp_pkg::REG_TRACE_LIFE, 32'hFFFF_FFFF);
        add_cmd(tsp_pkg::OP_INSERT, 1'b0, 32'd7);
        add_cmd(tsp_pkg::OP_TICK,   1'b0, 32'd7);
        add_cmd(tsp_pkg::OP_TICK,   1'b0, 32'd8);
        add_cmd(tsp_pkg::OP_INSERT, 1'b1, 32'hFFFF_FFFF);
        add_cmd(tsp_pkg::OP_TICK,   1'b0, 32'h00FF_FFFF);
        wait_idle();

        // Sender mostly busy, receiver mostly stalled.
        write_lifetime(tsp_pkg::REG_MARK_LIFE, 32'h00FF_FFFF);
        write_lifetime(tsp_pkg::REG_TRACE_LIFE, 32'h0000_0000);
        send_idle_pct = 14;
        recv_idle_pct = 87;
        queue_random(130);
        wait_idle();

        // Sender mostly idle, receiver mostly ready, random lifetimes.
        write_lifetime(tsp_pkg::REG_MARK_LIFE, $urandom_range(0, 70000));
        write_lifetime(tsp_pkg::REG_TRACE_LIFE, $urandom_range(0, 300));
        send_idle_pct = 87;
        recv_idle_pct = 14;
        queue_random(130);
        wait_idle();

        // Back to the reset lifetimes at full rate on both sides.
        write_lifetime(tsp_pkg::REG_MARK_LIFE, 32'(tsp_pkg::MARK_LIFE_RST));
        write_lifetime(tsp_pkg::REG_TRACE_LIFE, 32'(tsp_pkg::TRACE_LIFE_RST));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(130);
        wait_idle();
        repeat (40) @(posedge i_clk);

        if (expected_beats.size() != 0) begin
            report_mismatch("results never delivered", 0, expected_beats.size());
        end
        $display("Covered %0d inserts (%0d evicting the oldest) and %0d ticks freeing %0d slots,",
                 n_inserts, n_evicted, n_ticks, n_expired);
        $display("over %0d lifetime writes and %0d checked result beats.",
                 n_settings, beats_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- timed_slot_pool_oldest_evict.f -----
design/tsp_pkg.sv
design/tsp_regs.sv
design/tsp_alu.sv
design/tsp_seq.sv
design/timed_slot_pool_oldest_evict.sv
design/tsp_checker.sv
sim/tb_timed_slot_pool_oldest_evict.sv
